// File: rtl/assert_macros.svh
// assertion helpers used by the rtl (psd_engine)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define PSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: rtl/psd_pkg.sv
package psd_pkg;

	localparam int REPLAY_BYTES_DEF       = 32;
	localparam int MAX_MPEG1_STUFFING_DEF = 24;

	// parser phase
	localparam logic [1:0] PH_SYNC = 2'd0;
	localparam logic [1:0] PH_HDR  = 2'd1;
	localparam logic [1:0] PH_DROP = 2'd2;
	localparam logic [1:0] PH_PAY  = 2'd3;

	// configuration register indexes
	localparam logic REG_STREAM_SELECT    = 1'b0;
	localparam logic REG_SUBSTREAM_SELECT = 1'b1;

	// start codes
	localparam logic [7:0] CODE_END      = 8'hB9;
	localparam logic [7:0] CODE_PACK     = 8'hBA;
	localparam logic [7:0] CODE_SYS_HDR  = 8'hBB;
	localparam logic [7:0] CODE_PSM      = 8'hBC;
	localparam logic [7:0] CODE_PRIV1    = 8'hBD;
	localparam logic [7:0] CODE_STUFFING = 8'hBE;
	localparam logic [7:0] CODE_PRIV2    = 8'hBF;

	// field masks and marks
	localparam logic [7:0] MASK_NIB     = 8'hF0;
	localparam logic [7:0] MASK_TOP2    = 8'hC0;
	localparam logic [7:0] BYTE_STUFF   = 8'hFF;
	localparam logic [7:0] MARK_RESV    = 8'hF0;
	localparam logic [7:0] MARK_MPEG1   = 8'h20;
	localparam logic [7:0] MARK_MPEG2   = 8'h40;
	localparam logic [7:0] MARK_PES2    = 8'h80;
	localparam logic [7:0] MARK_STD     = 8'h40;
	localparam logic [7:0] MARK_PTS     = 8'h20;
	localparam logic [7:0] MARK_PTS_DTS = 8'h30;
	localparam logic [7:0] MARK_SUB_LPCM = 8'hA0;
	localparam logic [7:0] MARK_SUB_AC3  = 8'h80;

	typedef struct packed {
		logic [7:0] stream_sel;
		logic [7:0] sub_sel;
	} psd_cfg_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  payload_byte;
		logic [7:0]  stream_id;
		logic [7:0]  substream_id;
		logic        packet_start;
		logic [15:0] error_count;
		logic [15:0] packet_count;
	} psd_result_t;

endpackage

// File: rtl/psd_engine.sv
`include "assert_macros.svh"

module psd_engine #(
	parameter int REPLAY_BYTES       = psd_pkg::REPLAY_BYTES_DEF,
	parameter int MAX_MPEG1_STUFFING = psd_pkg::MAX_MPEG1_STUFFING_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [7:0]           in_byte,
	input  psd_pkg::psd_cfg_t    cfg,
	output logic                 busy,
	output psd_pkg::psd_result_t res
);

	localparam int StoreDepth = (REPLAY_BYTES > MAX_MPEG1_STUFFING + 12) ?
		REPLAY_BYTES : MAX_MPEG1_STUFFING + 12;
	localparam int Aw    = $clog2(StoreDepth);
	localparam int Depth = 1 << Aw;

	// header sub states
	localparam logic [3:0] HS_LEN   = 4'd0;
	localparam logic [3:0] HS_PACK  = 4'd1;
	localparam logic [3:0] HS_PACK2 = 4'd2;
	localparam logic [3:0] HS_PWAIT = 4'd3;
	localparam logic [3:0] HS_B6    = 4'd4;
	localparam logic [3:0] HS_M2    = 4'd5;
	localparam logic [3:0] HS_STUF  = 4'd6;
	localparam logic [3:0] HS_STD   = 4'd7;
	localparam logic [3:0] HS_FLAG  = 4'd8;
	localparam logic [3:0] HS_HWAIT = 4'd9;
	localparam logic [3:0] HS_SUB   = 4'd10;
	localparam logic [3:0] HS_TAIL  = 4'd11;

	// header decisions
	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_ERR  = 3'd1;
	localparam logic [2:0] ACT_SYNC = 3'd2;
	localparam logic [2:0] ACT_DROP = 3'd3;
	localparam logic [2:0] ACT_PES  = 3'd4;

	logic [7:0]    mem_q [Depth];
	logic [7:0]    rdata_s1;
	logic          rd_s1;

	logic [1:0]    phase_q, phase_n;
	logic [3:0]    hs_q, hs_n;
	logic [8:0]    hdr_q, hdr_n;
	logic [8:0]    tot_q, tot_n;
	logic [Aw-1:0] base_q, base_n;
	logic [7:0]    code_q, code_n;
	logic [15:0]   len_q, len_n;
	logic [7:0]    pk_q, pk_n;
	logic [8:0]    tgt_q, tgt_n;
	logic [7:0]    sub_q, sub_n;
	logic [15:0]   left_q, left_n;
	logic [7:0]    stream_q, stream_n;
	logic [7:0]    csub_q, csub_n;
	logic [15:0]   err_q, err_n;
	logic [15:0]   pkt_q, pkt_n;
	logic          start_q, start_n;

	logic          pending;
	logic          rd_go;
	logic          wr_go;
	logic          step;
	logic [7:0]    b;
	logic [8:0]    nf;
	logic [Aw-1:0] addr;
	logic          drop_code;
	logic          filt_drop;
	logic [2:0]    act;

	assign pending   = tot_q > hdr_q;
	assign busy      = pending | rd_s1;
	assign rd_go     = pending & ~rd_s1;
	assign addr      = base_q + hdr_q[Aw-1:0];
	assign step      = in_fire | rd_s1;
	assign b         = rd_s1 ? rdata_s1 : in_byte;
	assign nf        = rd_s1 ? tot_q : hdr_q + 9'd1;
	assign wr_go     = in_fire & (phase_q == psd_pkg::PH_SYNC || phase_q == psd_pkg::PH_HDR) &
		(hdr_q < 9'(StoreDepth));
	assign drop_code = (code_q == psd_pkg::CODE_SYS_HDR) || (code_q == psd_pkg::CODE_PSM) ||
		(code_q == psd_pkg::CODE_STUFFING) ||
		((code_q & psd_pkg::MASK_NIB) == psd_pkg::MARK_RESV);
	assign filt_drop = (cfg.stream_sel != 8'd0 && cfg.stream_sel != stream_q) ||
		(cfg.stream_sel != 8'd0 && cfg.sub_sel != 8'd0 && cfg.sub_sel != csub_q);

	// header memory
	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem_q[addr] <= in_byte;
		end
		if (rd_go) begin
			rdata_s1 <= mem_q[addr];
		end
	end

	always_comb begin
		logic [1:0]  m_new;
		logic        enter;
		logic        stuff_go;
		logic        flag_go;
		logic        post_go;
		logic [8:0]  disc;
		logic [16:0] total;
		logic [7:0]  fin_sub;
		logic [15:0] left_dec;

		phase_n  = phase_q;
		hs_n     = hs_q;
		hdr_n    = hdr_q;
		tot_n    = tot_q;
		base_n   = base_q;
		code_n   = code_q;
		len_n    = len_q;
		pk_n     = pk_q;
		tgt_n    = tgt_q;
		sub_n    = sub_q;
		left_n   = left_q;
		stream_n = stream_q;
		csub_n   = csub_q;
		err_n    = err_q;
		pkt_n    = pkt_q;
		start_n  = start_q;
		act      = ACT_NONE;
		m_new    = 2'd0;
		enter    = 1'b0;
		stuff_go = 1'b0;
		flag_go  = 1'b0;
		post_go  = 1'b0;
		disc     = 9'd0;
		total    = 17'd0;
		fin_sub  = 8'd0;
		left_dec = left_q;
		res      = '0;

		if (step) begin
			unique case (phase_q)
				psd_pkg::PH_SYNC: begin
					unique case (hdr_q[1:0])
						2'd0: m_new = (b == 8'h00) ? 2'd1 : 2'd0;
						2'd1: m_new = (b == 8'h00) ? 2'd2 : 2'd0;
						2'd2: m_new = (b == 8'h00) ? 2'd2 : ((b == 8'h01) ? 2'd3 : 2'd0);
						2'd3: begin
							if (b >= psd_pkg::CODE_PACK) begin
								enter = 1'b1;
							end else if (b == psd_pkg::CODE_END) begin
								m_new = 2'd0;
							end else begin
								m_new = (b == 8'h00) ? 2'd1 : 2'd0;
							end
						end
					endcase
					if (enter) begin
						phase_n = psd_pkg::PH_HDR;
						hs_n    = HS_LEN;
						code_n  = b;
						hdr_n   = 9'd4;
						tot_n   = nf;
					end else begin
						disc   = {7'd0, hdr_q[1:0]} + 9'd1 - {7'd0, m_new};
						base_n = base_q + disc[Aw-1:0];
						hdr_n  = {7'd0, m_new};
						tot_n  = nf - disc;
					end
				end
				psd_pkg::PH_HDR: begin
					hdr_n = hdr_q + 9'd1;
					tot_n = nf;
					unique case (hs_q)
						HS_LEN: begin
							if (hdr_q == 9'd4) begin
								len_n[15:8] = b;
								pk_n        = b;
							end else begin
								len_n[7:0] = b;
								if (code_q == psd_pkg::CODE_PACK) begin
									hs_n = HS_PACK;
								end else if (drop_code) begin
									act = ACT_DROP;
								end else begin
									hs_n = HS_B6;
								end
							end
						end
						HS_PACK: begin
							if (hdr_q == 9'd11) begin
								if ((pk_q & psd_pkg::MASK_NIB) == psd_pkg::MARK_MPEG1) begin
									act = ACT_SYNC;
								end else if ((pk_q & psd_pkg::MASK_TOP2) == psd_pkg::MARK_MPEG2) begin
									hs_n = HS_PACK2;
								end else begin
									act = ACT_ERR;
								end
							end
						end
						HS_PACK2: begin
							if (hdr_q == 9'd13) begin
								if (b[2:0] == 3'd0) begin
									act = ACT_SYNC;
								end else begin
									tgt_n = 9'd13 + {6'd0, b[2:0]};
									hs_n  = HS_PWAIT;
								end
							end
						end
						HS_PWAIT: begin
							if (hdr_q == tgt_q) begin
								act = ACT_SYNC;
							end
						end
						HS_B6: begin
							if (code_q == psd_pkg::CODE_PRIV2) begin
								act = ACT_PES;
							end else if ((b & psd_pkg::MASK_TOP2) == psd_pkg::MARK_PES2) begin
								hs_n = HS_M2;
							end else begin
								stuff_go = 1'b1;
							end
						end
						HS_M2: begin
							if (hdr_q == 9'd8) begin
								if (b == 8'd0) begin
									post_go = 1'b1;
								end else begin
									tgt_n = {1'b0, b} + 9'd8;
									hs_n  = HS_HWAIT;
								end
							end
						end
						HS_STUF:  stuff_go = 1'b1;
						HS_STD:   hs_n = HS_FLAG;
						HS_FLAG:  flag_go = 1'b1;
						HS_HWAIT: begin
							if (hdr_q == tgt_q) begin
								post_go = 1'b1;
							end
						end
						HS_SUB: begin
							sub_n = b;
							if ((b & psd_pkg::MASK_NIB) == psd_pkg::MARK_SUB_AC3) begin
								tgt_n = hdr_q + 9'd3;
								hs_n  = HS_TAIL;
							end else if ((b & psd_pkg::MASK_NIB) == psd_pkg::MARK_SUB_LPCM) begin
								tgt_n = hdr_q + 9'd6;
								hs_n  = HS_TAIL;
							end else begin
								fin_sub = b;
								act     = ACT_PES;
							end
						end
						HS_TAIL: begin
							if (hdr_q == tgt_q) begin
								fin_sub = sub_q;
								act     = ACT_PES;
							end
						end
						default: act = ACT_SYNC;
					endcase

					if (stuff_go) begin
						if (b == psd_pkg::BYTE_STUFF) begin
							if (hdr_q >= 9'(MAX_MPEG1_STUFFING - 1)) begin
								act = ACT_ERR;
							end else begin
								hs_n = HS_STUF;
							end
						end else if ((b & psd_pkg::MASK_TOP2) == psd_pkg::MARK_STD) begin
							hs_n = HS_STD;
						end else begin
							flag_go = 1'b1;
						end
					end
					if (flag_go) begin
						if ((b & psd_pkg::MASK_NIB) == psd_pkg::MARK_PTS) begin
							tgt_n = hdr_q + 9'd4;
							hs_n  = HS_HWAIT;
						end else if ((b & psd_pkg::MASK_NIB) == psd_pkg::MARK_PTS_DTS) begin
							tgt_n = hdr_q + 9'd9;
							hs_n  = HS_HWAIT;
						end else begin
							post_go = 1'b1;
						end
					end
					if (post_go) begin
						if (code_q == psd_pkg::CODE_PRIV1) begin
							hs_n = HS_SUB;
						end else begin
							act = ACT_PES;
						end
					end

					total = 17'd6 + {1'b0, len_n};
					unique case (act)
						ACT_NONE: ;
						ACT_ERR: begin
							base_n  = base_q + Aw'(1);
							tot_n   = nf - 9'd1;
							hdr_n   = 9'd0;
							phase_n = psd_pkg::PH_SYNC;
							if (err_q != 16'hFFFF) begin
								err_n = err_q + 16'd1;
							end
						end
						ACT_SYNC: begin
							tot_n   = 9'd0;
							hdr_n   = 9'd0;
							phase_n = psd_pkg::PH_SYNC;
						end
						ACT_DROP, ACT_PES: begin
							tot_n = 9'd0;
							hdr_n = 9'd0;
							if (act == ACT_PES) begin
								stream_n = code_q;
								csub_n   = fin_sub;
								if (pkt_q != 16'hFFFF) begin
									pkt_n = pkt_q + 16'd1;
								end
							end
							if (total > {8'd0, nf}) begin
								left_n = 16'(total - {8'd0, nf});
								if (act == ACT_PES) begin
									phase_n = psd_pkg::PH_PAY;
									start_n = 1'b1;
								end else begin
									phase_n = psd_pkg::PH_DROP;
								end
							end else begin
								phase_n = psd_pkg::PH_SYNC;
							end
						end
						default: ;
					endcase
				end
				psd_pkg::PH_DROP, psd_pkg::PH_PAY: begin
					if (left_q != 16'd0) begin
						left_dec = left_q - 16'd1;
					end
					left_n = left_dec;
					if (left_dec == 16'd0) begin
						phase_n = psd_pkg::PH_SYNC;
					end
					if (phase_q == psd_pkg::PH_PAY && !filt_drop) begin
						res.valid        = 1'b1;
						res.payload_byte = b;
						res.stream_id    = stream_q;
						res.substream_id = csub_q;
						res.packet_start = start_q;
						res.error_count  = err_q;
						res.packet_count = pkt_q;
						start_n          = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1    <= 1'b0;
			phase_q  <= psd_pkg::PH_SYNC;
			hs_q     <= HS_LEN;
			hdr_q    <= 9'd0;
			tot_q    <= 9'd0;
			base_q   <= '0;
			left_q   <= 16'd0;
			stream_q <= 8'd0;
			csub_q   <= 8'd0;
			err_q    <= 16'd0;
			pkt_q    <= 16'd0;
			start_q  <= 1'b0;
		end else begin
			rd_s1    <= rd_go;
			phase_q  <= phase_n;
			hs_q     <= hs_n;
			hdr_q    <= hdr_n;
			tot_q    <= tot_n;
			base_q   <= base_n;
			left_q   <= left_n;
			stream_q <= stream_n;
			csub_q   <= csub_n;
			err_q    <= err_n;
			pkt_q    <= pkt_n;
			start_q  <= start_n;
		end
	end

	always_ff @(posedge clk) begin
		code_q <= code_n;
		len_q  <= len_n;
		pk_q   <= pk_n;
		tgt_q  <= tgt_n;
		sub_q  <= sub_n;
	end

	`PSD_ASSERT_IMP(a_no_overlap, clk, arst_n, rd_s1, !in_fire, "input item taken during replay")
	`PSD_ASSERT_IMP(a_sync_prefix, clk, arst_n, phase_q == psd_pkg::PH_SYNC, hdr_q < 9'd4, "sync prefix too long")
	`PSD_ASSERT_IMP(a_res_phase, clk, arst_n, res.valid, phase_q == psd_pkg::PH_PAY, "result outside payload")
	`PSD_ASSERT_NXT(a_err_replay, clk, arst_n, step && act == ACT_ERR, pending, "false sync left nothing to rescan")

endmodule

// File: rtl/program_stream_demux_unit.sv
// a payload item shows on the output register in the cycle after its input item is taken
// throughput: one input item per cycle unless a false sync is handled or the output stalls
// after a false sync the buffered header bytes are rescanned from the header memory,
// one byte per registered read of its single port, up to MAX_MPEG1_STUFFING-1 bytes
// reset: asynchronous, clears parser phase, counters and selects; header memory is not cleared
module program_stream_demux_unit #(
	parameter int REPLAY_BYTES       = psd_pkg::REPLAY_BYTES_DEF,
	parameter int MAX_MPEG1_STUFFING = psd_pkg::MAX_MPEG1_STUFFING_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  payload_byte,
	output logic [7:0]  stream_id,
	output logic [7:0]  substream_id,
	output logic        packet_start,
	output logic [15:0] error_count,
	output logic [15:0] packet_count
);

	psd_pkg::psd_cfg_t    cfg_q;
	psd_pkg::psd_result_t res;
	psd_pkg::psd_result_t out_q;
	logic                 out_valid_q;
	logic                 busy;
	logic                 in_fire;

	assign in_ready = ~busy & (~out_valid_q | out_ready);
	assign in_fire  = in_valid & in_ready;

	psd_engine #(
		.REPLAY_BYTES      (REPLAY_BYTES),
		.MAX_MPEG1_STUFFING(MAX_MPEG1_STUFFING)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.in_fire(in_fire),
		.in_byte(data_byte),
		.cfg    (cfg_q),
		.busy   (busy),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					psd_pkg::REG_STREAM_SELECT:    cfg_q.stream_sel <= cfg_data;
					psd_pkg::REG_SUBSTREAM_SELECT: cfg_q.sub_sel <= cfg_data;
				endcase
			end
			if (res.valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output item register
	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_q.payload_byte;
	assign stream_id    = out_q.stream_id;
	assign substream_id = out_q.substream_id;
	assign packet_start = out_q.packet_start;
	assign error_count  = out_q.error_count;
	assign packet_count = out_q.packet_count;

endmodule

// File: tb/tb_program_stream_demux_unit.sv
module tb_program_stream_demux_unit;

	localparam int STUFF_LIMIT = psd_pkg::MAX_MPEG1_STUFFING_DEF;
	localparam int HDR_DEPTH = (psd_pkg::REPLAY_BYTES_DEF > STUFF_LIMIT + 12) ?
		psd_pkg::REPLAY_BYTES_DEF : STUFF_LIMIT + 12;
	localparam int HDR_NEED = 0;
	localparam int HDR_AGAIN = 1;
	localparam int HDR_DONE = 2;
	localparam int SETTLE_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = psd_pkg::REG_STREAM_SELECT;
	logic [7:0] cfg_data = 8'h00;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] payload_byte, stream_id, substream_id;
	logic packet_start;
	logic [15:0] error_count, packet_count;

	program_stream_demux_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.payload_byte(payload_byte), .stream_id(stream_id), .substream_id(substream_id),
		.packet_start(packet_start), .error_count(error_count), .packet_count(packet_count)
	);

	always #5 clk = ~clk;

	// parser mirror
	logic [1:0] pm_phase;
	logic [7:0] pm_store [HDR_DEPTH];
	int pm_fill;
	int pm_left;
	logic [7:0] pm_stream, pm_sub;
	int pm_errors, pm_packets;
	bit pm_start;
	logic [7:0] sel_stream, sel_sub;

	psd_pkg::psd_result_t payload_q[$];
	logic [7:0] pstream[$];
	int in_idle = 0;
	int out_idle = 0;
	int fail_count = 0;
	int bytes_sent = 0;
	int payload_checked = 0;

	function automatic logic [7:0] hdr_byte(int i, logic [7:0] cur);
		if (i < HDR_DEPTH) return pm_store[i];
		if (i + 1 == pm_fill) return cur;
		return 8'h00;
	endfunction

	function automatic void hdr_shift(int n);
		int kept;
		if (n >= pm_fill) begin
			pm_fill = 0;
			return;
		end
		kept = (pm_fill < HDR_DEPTH) ? pm_fill : HDR_DEPTH;
		for (int i = 0; i < kept - n; i++) pm_store[i] = pm_store[i + n];
		pm_fill -= n;
	endfunction

	function automatic void false_sync();
		if (pm_errors < 16'hFFFF) pm_errors++;
		hdr_shift(1);
		pm_phase = psd_pkg::PH_SYNC;
	endfunction

	function automatic void back_to_sync();
		pm_fill = 0;
		pm_phase = psd_pkg::PH_SYNC;
	endfunction

	function automatic int skip_packet(logic [7:0] cur);
		int total;
		if (pm_fill < 6) return HDR_NEED;
		total = 6 + {hdr_byte(4, cur), hdr_byte(5, cur)};
		if (total > pm_fill) begin
			pm_left = total - pm_fill;
			pm_fill = 0;
			pm_phase = psd_pkg::PH_DROP;
		end else begin
			back_to_sync();
		end
		return HDR_DONE;
	endfunction

	function automatic int parse_header(logic [7:0] cur);
		logic [7:0] code, b, sub;
		int pos, total;
		code = pm_store[3];
		sub = 8'h00;
		if (code == psd_pkg::CODE_PACK) begin
			if (pm_fill < 12) return HDR_NEED;
			b = hdr_byte(4, cur);
			if ((b & psd_pkg::MASK_NIB) == psd_pkg::MARK_MPEG1) begin
				back_to_sync();
				return HDR_DONE;
			end
			if ((b & psd_pkg::MASK_TOP2) == psd_pkg::MARK_MPEG2) begin
				if (pm_fill < 14) return HDR_NEED;
				if (pm_fill < 14 + int'(hdr_byte(13, cur) & 8'h07)) return HDR_NEED;
				back_to_sync();
				return HDR_DONE;
			end
			false_sync();
			return HDR_AGAIN;
		end
		if (code == psd_pkg::CODE_SYS_HDR || code == psd_pkg::CODE_PSM ||
				code == psd_pkg::CODE_STUFFING ||
				(code & psd_pkg::MASK_NIB) == psd_pkg::MARK_RESV)
			return skip_packet(cur);
		if (pm_fill < 7) return HDR_NEED;
		pos = 6;
		if (code != psd_pkg::CODE_PRIV2) begin
			if ((hdr_byte(6, cur) & psd_pkg::MASK_TOP2) == psd_pkg::MARK_PES2) begin
				if (pm_fill < 9) return HDR_NEED;
				pos = int'(hdr_byte(8, cur)) + 9;
				if (pm_fill < pos) return HDR_NEED;
			end else begin
				while (pos < pm_fill && hdr_byte(pos, cur) == psd_pkg::BYTE_STUFF) pos++;
				if (pos == pm_fill) begin
					if (pm_fill < STUFF_LIMIT) return HDR_NEED;
					false_sync();
					return HDR_AGAIN;
				end
				if ((hdr_byte(pos, cur) & psd_pkg::MASK_TOP2) == psd_pkg::MARK_STD) begin
					pos += 2;
					if (pm_fill < pos + 1) return HDR_NEED;
				end
				b = hdr_byte(pos, cur) & psd_pkg::MASK_NIB;
				if (b == psd_pkg::MARK_PTS) pos += 5;
				else if (b == psd_pkg::MARK_PTS_DTS) pos += 10;
				else pos += 1;
				if (pm_fill < pos) return HDR_NEED;
			end
		end
		if (code == psd_pkg::CODE_PRIV1) begin
			pos++;
			if (pm_fill < pos) return HDR_NEED;
			if (pos - 1 < HDR_DEPTH) sub = pm_store[pos - 1];
			else if (pos == pm_fill) sub = cur;
			else sub = pm_sub;
			pm_sub = sub;
			if ((sub & psd_pkg::MASK_NIB) == psd_pkg::MARK_SUB_AC3 && pm_fill < pos + 3)
				return HDR_NEED;
			if ((sub & psd_pkg::MASK_NIB) == psd_pkg::MARK_SUB_LPCM && pm_fill < pos + 6)
				return HDR_NEED;
		end
		pm_stream = code;
		pm_sub = sub;
		if (pm_packets < 16'hFFFF) pm_packets++;
		total = 6 + {hdr_byte(4, cur), hdr_byte(5, cur)};
		if (total > pm_fill) begin
			pm_left = total - pm_fill;
			pm_start = 1'b1;
			pm_fill = 0;
			pm_phase = psd_pkg::PH_PAY;
		end else begin
			back_to_sync();
		end
		return HDR_DONE;
	endfunction

	function automatic void scan_header(logic [7:0] cur);
		bit ok;
		int lim;
		while (1) begin
			if (pm_phase == psd_pkg::PH_SYNC) begin
				ok = 1'b0;
				while (!ok) begin
					lim = (pm_fill < 3) ? pm_fill : 3;
					ok = 1'b1;
					for (int k = 0; k < lim; k++)
						if (pm_store[k] != ((k == 2) ? 8'h01 : 8'h00)) ok = 1'b0;
					if (!ok) hdr_shift(1);
				end
				if (pm_fill < 4) return;
				if (pm_store[3] < psd_pkg::CODE_END) begin
					hdr_shift(1);
					continue;
				end
				if (pm_store[3] == psd_pkg::CODE_END) begin
					hdr_shift(4);
					continue;
				end
				pm_phase = psd_pkg::PH_HDR;
			end
			if (pm_phase != psd_pkg::PH_HDR) return;
			if (parse_header(cur) != HDR_AGAIN) return;
		end
	endfunction

	function automatic void predict_payload(logic [7:0] cur);
		psd_pkg::psd_result_t r;
		bit dropped;
		if (pm_phase == psd_pkg::PH_PAY) begin
			dropped = (sel_stream != 0 && sel_stream != pm_stream) ||
				(sel_stream != 0 && sel_sub != 0 && sel_sub != pm_sub);
			if (pm_left > 0) pm_left--;
			if (pm_left == 0) back_to_sync();
			if (dropped) return;
			r.valid = 1'b1;
			r.payload_byte = cur;
			r.stream_id = pm_stream;
			r.substream_id = pm_sub;
			r.packet_start = pm_start;
			r.error_count = pm_errors[15:0];
			r.packet_count = pm_packets[15:0];
			pm_start = 1'b0;
			payload_q.push_back(r);
			return;
		end
		if (pm_phase == psd_pkg::PH_DROP) begin
			if (pm_left > 0) pm_left--;
			if (pm_left == 0) back_to_sync();
			return;
		end
		if (pm_fill < HDR_DEPTH) pm_store[pm_fill] = cur;
		if (pm_fill < 511) pm_fill++;
		scan_header(cur);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk) begin
		psd_pkg::psd_result_t e;
		out_ready <= ($urandom_range(99) >= out_idle);
		if (arst_n && out_valid && out_ready) begin
			if (payload_q.size() == 0) begin
				report_mismatch("unexpected item", payload_byte, 0);
			end else begin
				e = payload_q.pop_front();
				payload_checked++;
				if (payload_byte !== e.payload_byte)
					report_mismatch("payload_byte", payload_byte, e.payload_byte);
				if (stream_id !== e.stream_id)
					report_mismatch("stream_id", stream_id, e.stream_id);
				if (substream_id !== e.substream_id)
					report_mismatch("substream_id", substream_id, e.substream_id);
				if (packet_start !== e.packet_start)
					report_mismatch("packet_start", packet_start, e.packet_start);
				if (error_count !== e.error_count)
					report_mismatch("error_count", error_count, e.error_count);
				if (packet_count !== e.packet_count)
					report_mismatch("packet_count", packet_count, e.packet_count);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < in_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_payload(b);
		bytes_sent++;
	endtask

	task automatic flush_stream();
		while (pstream.size() != 0) send_byte(pstream.pop_front());
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		flush_stream();
		while (payload_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == psd_pkg::REG_STREAM_SELECT) sel_stream = val;
		else sel_sub = val;
	endtask

	task automatic add_start(input logic [7:0] code);
		pstream.push_back(8'h00);
		pstream.push_back(8'h00);
		pstream.push_back(8'h01);
		pstream.push_back(code);
	endtask

	task automatic add_random(input int n);
		repeat (n) pstream.push_back(8'($urandom));
	endtask

	task automatic add_pack(input int kind, input int stuff);
		add_start(psd_pkg::CODE_PACK);
		if (kind == 1) begin
			pstream.push_back(psd_pkg::MARK_MPEG1 | 8'($urandom_range(15)));
			add_random(7);
		end else if (kind == 2) begin
			pstream.push_back(8'($urandom_range(1)) ? 8'($urandom_range(8'h1F)) :
				8'($urandom_range(8'hC0, 8'hFF)));
			add_random(7);
		end else begin
			pstream.push_back(psd_pkg::MARK_MPEG2 | 8'($urandom_range(63)));
			add_random(8);
			pstream.push_back((8'($urandom) & 8'hF8) | 8'(stuff));
			repeat (stuff) pstream.push_back(psd_pkg::BYTE_STUFF);
		end
	endtask

	task automatic add_skip(input logic [7:0] code, input int len);
		add_start(code);
		pstream.push_back(8'(len >> 8));
		pstream.push_back(8'(len));
		add_random(len);
	endtask

	// kind: 0 mpeg2, 1 mpeg1, 2 mpeg2 long header, 3 mpeg1 overlong stuffing
	task automatic add_pes(input logic [7:0] code, input int kind, input int pay_n,
			input bit short_len, input logic [7:0] sub);
		logic [7:0] hdr[$];
		int len, h, m;
		if (code != psd_pkg::CODE_PRIV2) begin
			if (kind == 0 || kind == 2) begin
				h = (kind == 2) ? 40 : $urandom_range(0, 6);
				hdr.push_back(psd_pkg::MARK_PES2 | 8'($urandom_range(63)));
				hdr.push_back(8'($urandom));
				hdr.push_back(8'(h));
				repeat (h) hdr.push_back(8'($urandom));
			end else if (kind == 3) begin
				repeat (30) hdr.push_back(psd_pkg::BYTE_STUFF);
			end else begin
				repeat ($urandom_range(0, 4)) hdr.push_back(psd_pkg::BYTE_STUFF);
				if ($urandom_range(1)) begin
					hdr.push_back(psd_pkg::MARK_STD | 8'($urandom_range(63)));
					hdr.push_back(8'($urandom));
				end
				m = $urandom_range(2);
				if (m == 0) begin
					hdr.push_back(psd_pkg::MARK_PTS | 8'($urandom_range(15)));
					repeat (4) hdr.push_back(8'($urandom));
				end else if (m == 1) begin
					hdr.push_back(psd_pkg::MARK_PTS_DTS | 8'($urandom_range(15)));
					repeat (9) hdr.push_back(8'($urandom));
				end else begin
					hdr.push_back(8'h0F);
				end
			end
		end
		if (code == psd_pkg::CODE_PRIV1) begin
			hdr.push_back(sub);
			if ((sub & psd_pkg::MASK_NIB) == psd_pkg::MARK_SUB_AC3)
				repeat (3) hdr.push_back(8'($urandom));
			if ((sub & psd_pkg::MASK_NIB) == psd_pkg::MARK_SUB_LPCM)
				repeat (6) hdr.push_back(8'($urandom));
		end
		len = short_len ? $urandom_range(0, hdr.size()) : hdr.size() + pay_n;
		add_start(code);
		pstream.push_back(8'(len >> 8));
		pstream.push_back(8'(len));
		foreach (hdr[i]) pstream.push_back(hdr[i]);
		if (!short_len) add_random(pay_n);
	endtask

	function automatic logic [7:0] pick_sub();
		case ($urandom_range(3))
			0: return psd_pkg::MARK_SUB_AC3 | 8'($urandom_range(1));
			1: return psd_pkg::MARK_SUB_LPCM | 8'($urandom_range(1));
			2: return 8'h20 | 8'($urandom_range(1));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_stream();
		case ($urandom_range(4))
			0: return 8'hC0;
			1: return 8'hE0;
			2: return psd_pkg::CODE_PRIV1;
			3: return psd_pkg::CODE_PRIV2;
			default: return 8'($urandom_range(8'hC0, 8'hEF));
		endcase
	endfunction

	task automatic add_unit();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			add_pes(pick_stream(), $urandom_range(1), $urandom_range(0, 24), 1'b0, pick_sub());
		else if (r < 62) add_pack(0, $urandom_range(7));
		else if (r < 70) add_pack(1, 0);
		else if (r < 78) begin
			case ($urandom_range(3))
				0: add_skip(psd_pkg::CODE_SYS_HDR, $urandom_range(0, 12));
				1: add_skip(psd_pkg::CODE_PSM, $urandom_range(0, 12));
				2: add_skip(psd_pkg::CODE_STUFFING, $urandom_range(0, 12));
				default: add_skip(psd_pkg::MARK_RESV | 8'($urandom_range(15)),
					$urandom_range(0, 12));
			endcase
		end
		else if (r < 82) add_start(psd_pkg::CODE_END);
		else if (r < 87) begin
			add_random($urandom_range(1, 6));
			add_start(8'($urandom_range(8'hB8)));
		end
		else if (r < 92) add_pack(2, 0);
		else if (r < 95) add_pes(pick_stream(), $urandom_range(1), 0, 1'b1, pick_sub());
		else if (r < 98) add_pes(8'hC0, 3, 4, 1'b0, 8'h00);
		else add_pes(8'hE0, 2, $urandom_range(0, 8), 1'b0, 8'h00);
	endtask

	task automatic test_directed();
		add_pack(0, 7);
		add_pack(0, 0);
		add_pack(1, 0);
		add_pack(2, 0);
		add_start(psd_pkg::CODE_END);
		add_start(8'h42);
		add_start(8'h00);
		add_skip(psd_pkg::CODE_SYS_HDR, 3);
		add_skip(psd_pkg::CODE_PSM, 0);
		add_skip(psd_pkg::CODE_STUFFING, 5);
		add_skip(8'hF0, 2);
		add_skip(8'hFF, 1);
		add_pes(8'hE0, 0, 4, 1'b0, 8'h00);
		pstream.push_back(8'h00);
		pstream.push_back(8'hFF);
		add_pes(8'hC0, 1, 3, 1'b0, 8'h00);
		add_pes(8'hC0, 1, 0, 1'b0, 8'h00);
		add_pes(psd_pkg::CODE_PRIV1, 0, 3, 1'b0, psd_pkg::MARK_SUB_AC3);
		add_pes(psd_pkg::CODE_PRIV1, 1, 3, 1'b0, psd_pkg::MARK_SUB_LPCM);
		add_pes(psd_pkg::CODE_PRIV1, 0, 2, 1'b0, 8'h20);
		add_pes(psd_pkg::CODE_PRIV2, 0, 5, 1'b0, 8'h00);
		add_pes(8'hE0, 0, 0, 1'b1, 8'h00);
		add_pes(8'hC0, 3, 4, 1'b0, 8'h00);
		add_pes(8'hE0, 2, 3, 1'b0, 8'h00);
		add_pes(8'hEF, 0, 2, 1'b0, 8'h00);
		wait_drained();
	endtask

	task automatic test_filters();
		logic [7:0] streams[6] = '{8'hE0, psd_pkg::CODE_PRIV1, psd_pkg::CODE_PRIV1, 8'hFF,
			8'hC0, 8'h00};
		logic [7:0] subs[6] = '{8'h00, psd_pkg::MARK_SUB_AC3, psd_pkg::MARK_SUB_LPCM, 8'hFF,
			8'hFF, 8'hFF};
		for (int i = 0; i < 6; i++) begin
			write_reg(psd_pkg::REG_STREAM_SELECT, streams[i]);
			write_reg(psd_pkg::REG_SUBSTREAM_SELECT, subs[i]);
			repeat (3) add_unit();
			add_pes(psd_pkg::CODE_PRIV1, 0, 3, 1'b0, subs[i]);
			add_pes(streams[i], 0, 3, 1'b0, psd_pkg::MARK_SUB_AC3);
		end
		write_reg(psd_pkg::REG_STREAM_SELECT, 8'h00);
		write_reg(psd_pkg::REG_SUBSTREAM_SELECT, 8'h00);
	endtask

	task automatic test_random(input int send_idle, input int recv_idle, input int n_bytes);
		int stop_at;
		in_idle = send_idle;
		out_idle = recv_idle;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			add_unit();
			flush_stream();
		end
		wait_drained();
	endtask

	initial begin
		sel_stream = 8'h00;
		sel_sub = 8'h00;
		pm_phase = psd_pkg::PH_SYNC;
		pm_fill = 0;
		pm_left = 0;
		pm_stream = 8'h00;
		pm_sub = 8'h00;
		pm_errors = 0;
		pm_packets = 0;
		pm_start = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		in_idle = 10;
		out_idle = 73;
		test_directed();
		test_filters();
		test_random(10, 73, 170);
		test_random(73, 10, 170);
		test_random(0, 0, 170);
		$display("sent %0d stream bytes, checked %0d payload items", bytes_sent,
			payload_checked);
		$display("parser saw %0d packets and %0d false syncs", pm_packets, pm_errors);
		if (fail_count == 0 && payload_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("status: fail");
		$finish;
	end

endmodule
